/* src/pid3_pkg.sv */
// Package: shared constants, types and a helper function for the three-axis PID controller.
package pid3_pkg;

  localparam int AXES     = 3;
  localparam int LANES    = (AXES < 3) ? AXES : 3;
  localparam int NREGS    = 7;
  localparam int REG_W    = 48;
  localparam int PDATA_W  = 64;
  localparam int PADDR_W  = 6;
  localparam int YAW_AXIS = 2;

  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_IHI  = 3'd3;
  localparam logic [2:0] REG_ILO  = 3'd4;
  localparam logic [2:0] REG_DHI  = 3'd5;
  localparam logic [2:0] REG_DLO  = 3'd6;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [15:0] HALF_TURN = 16'sd11520;
  localparam logic signed [15:0] FULL_TURN = 16'sd23040;

  typedef struct packed {
    logic                start;
    logic                clr;
    logic                integ_en;
    logic signed [15:0]  err;
    logic signed [14:0]  ang;
    logic [15:0]         tstep;
  } lane_cmd_t;

  typedef struct packed {
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        kd;
    logic signed [15:0] ihi;
    logic signed [15:0] ilo;
    logic signed [15:0] dhi;
    logic signed [15:0] dlo;
  } lane_cfg_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic signed [15:0] torque;
  } lane_sts_t;

  function automatic logic signed [15:0] axis_err(input logic signed [14:0] tgt,
                                                  input logic signed [14:0] ang,
                                                  input logic wrap);
    logic signed [15:0] e;
    e = 16'(tgt) - 16'(ang);
    if (wrap) begin
      if (e > HALF_TURN) begin
        e = e - FULL_TURN;
      end else if (e < -HALF_TURN) begin
        e = e + FULL_TURN;
      end
    end
    return e;
  endfunction

endpackage

/* src/pid3_ifs.sv */
// Interfaces: update input channel and torque result channel.
interface pid3_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [14:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] yaw_angle;
  logic signed [14:0] roll_target;
  logic signed [14:0] pitch_target;
  logic signed [14:0] yaw_target;
  logic [15:0]        time_step;
  logic               integrate_enable;

  modport source (output valid, opcode, roll_angle, pitch_angle, yaw_angle, roll_target,
                  pitch_target, yaw_target, time_step, integrate_enable, input ready);
  modport sink (input valid, opcode, roll_angle, pitch_angle, yaw_angle, roll_target,
                pitch_target, yaw_target, time_step, integrate_enable, output ready);
endinterface

interface pid3_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_torque;
  logic signed [15:0] pitch_torque;
  logic signed [15:0] yaw_torque;

  modport source (output valid, roll_torque, pitch_torque, yaw_torque, input ready);
  modport sink (input valid, roll_torque, pitch_torque, yaw_torque, output ready);
endinterface

/* src/pid3_lane.sv */
// Per-axis PID lane: multiplies, integrator clamp, serial derivative divide, torque clamp.
module pid3_lane import pid3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_cmd_t cmd,
  input  lane_cfg_t cfg,
  input  logic      ack,
  output lane_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int NUM_W = 42;

  logic [2:0]         state_r, state_nxt;
  logic signed [31:0] integ_r;
  logic signed [14:0] prev_r;
  logic signed [15:0] e_r;
  logic signed [15:0] diff_r;
  logic [15:0]        t_r;
  logic [15:0]        tdiv_r;
  logic               ien_r;
  logic signed [32:0] pe_r;
  logic [31:0]        gt_r;
  logic signed [32:0] dm_r;
  logic signed [48:0] ie_r;
  logic [NUM_W-1:0]   quo_r;
  logic [15:0]        rem_r;
  logic               neg_r;
  logic [5:0]         cnt_r;
  logic signed [15:0] torque_r;

  logic signed [48:0] ie_sh;
  logic signed [42:0] s_sum, s_hi, s_lo, s_new;
  logic [32:0]        dm_abs;
  logic [16:0]        rsh;
  logic               qbit;
  logic signed [32:0] pe_sh;
  logic signed [42:0] d_val;
  logic signed [44:0] tsum, tclamp;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.start && !cmd.clr) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_INT;
      S_INT:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'(NUM_W - 1)) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: if (ack) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ie_sh  = ie_r >>> 7;
    s_sum  = 43'(integ_r) + ie_sh[42:0];
    s_hi   = 43'(cfg.ihi) <<< 16;
    s_lo   = 43'(cfg.ilo) <<< 16;
    s_new  = s_sum;
    if (s_new > s_hi) s_new = s_hi;
    if (s_new < s_lo) s_new = s_lo;
    dm_abs = dm_r[32] ? 33'(-dm_r) : 33'(dm_r);
    rsh    = {rem_r, quo_r[NUM_W-1]};
    qbit   = (rsh >= {1'b0, tdiv_r});
    pe_sh  = pe_r >>> 7;
    d_val  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    tsum   = 45'(pe_sh) + 45'($signed(integ_r[31:16])) + 45'(d_val);
    tclamp = tsum;
    if (tclamp > 45'(cfg.dhi)) tclamp = 45'(cfg.dhi);
    if (tclamp < 45'(cfg.dlo)) tclamp = 45'(cfg.dlo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && cmd.start) begin
        if (cmd.clr) begin
          integ_r <= '0;
        end else begin
          prev_r <= cmd.ang;
        end
      end
      if (state_r == S_INT && ien_r) integ_r <= 32'(s_new);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        e_r    <= cmd.err;
        diff_r <= 16'(prev_r) - 16'(cmd.ang);
        t_r    <= cmd.tstep;
        tdiv_r <= (cmd.tstep == 16'd0) ? 16'd1 : cmd.tstep;
        ien_r  <= cmd.integ_en;
      end
      S_MUL1: begin
        pe_r <= $signed({17'd0, cfg.kp}) * $signed({{17{e_r[15]}}, e_r});
        gt_r <= cfg.ki * t_r;
        dm_r <= $signed({17'd0, cfg.kd}) * $signed({{17{diff_r[15]}}, diff_r});
      end
      S_MUL2: begin
        ie_r  <= $signed({17'd0, gt_r}) * $signed({{33{e_r[15]}}, e_r});
        quo_r <= {dm_abs, 9'd0};
        neg_r <= dm_r[32];
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_INT: begin
      end
      S_DIV: begin
        rem_r <= qbit ? 16'(rsh - {1'b0, tdiv_r}) : rsh[15:0];
        quo_r <= {quo_r[NUM_W-2:0], qbit};
        cnt_r <= cnt_r + 6'd1;
      end
      S_SUM: torque_r <= 16'(tclamp);
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign sts.idle   = (state_r == S_IDLE);
  assign sts.done   = (state_r == S_DONE);
  assign sts.torque = torque_r;

endmodule

/* src/pid3_merge.sv */
// Merge stage: joins lane torques into the result register and releases the lanes.
module pid3_merge import pid3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_sts_t sts [LANES],
  output logic      ack,
  pid3_out_if.source out_ch
);

  logic               all_done;
  logic               valid_r;
  logic signed [15:0] tq_r [3];
  logic signed [15:0] tq_all [3];

  always_comb begin
    all_done = 1'b1;
    for (int a = 0; a < LANES; a++) begin
      all_done = all_done & sts[a].done;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_map
    if (a < LANES) begin : g_on
      assign tq_all[a] = sts[a].torque;
    end else begin : g_off
      assign tq_all[a] = '0;
    end
  end

  assign ack = all_done && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ack) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      for (int a = 0; a < 3; a++) tq_r[a] <= tq_all[a];
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.roll_torque  = tq_r[0];
  assign out_ch.pitch_torque = tq_r[1];
  assign out_ch.yaw_torque   = tq_r[2];

endmodule

/* src/three_axis_pid_controller_unit.sv */
// Top level: three-axis PID attitude controller with APB register file.
// An update transaction runs the lanes side by side from acceptance to a result in the output
// register; each lane runs multiply, integrate, the 42-step restoring divider for the
// derivative term and sum, in that order. A new update is taken only after the previous
// result enters the output register, which waits while the output channel is not ready.
// A clear transaction is absorbed without making the controller busy and yields no result.
// Registers sit at byte address 8*i, 48 bits in 64-bit data.
module three_axis_pid_controller_unit import pid3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  pid3_in_if.sink            in_ch,
  pid3_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [REG_W-1:0]   regs_r [NREGS];
  logic               busy_r;
  logic               ack;
  logic               acc;
  logic [2:0]         widx;
  logic signed [14:0] ang [3];
  logic signed [14:0] tgt [3];
  lane_cmd_t          cmd [LANES];
  lane_cfg_t          lcfg [LANES];
  lane_sts_t          sts [LANES];
  logic               all_idle;

  assign pready = 1'b1;
  assign widx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) regs_r[i] <= '0;
    end else if (psel && penable && pwrite && widx < 3'(NREGS)) begin
      regs_r[widx] <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (widx < 3'(NREGS)) prdata = {{(PDATA_W-REG_W){1'b0}}, regs_r[widx]};
  end

  assign in_ch.ready = !busy_r;
  assign acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (acc && in_ch.opcode == OP_UPDATE) begin
      busy_r <= 1'b1;
    end else if (ack) begin
      busy_r <= 1'b0;
    end
  end

  assign ang[0] = in_ch.roll_angle;
  assign ang[1] = in_ch.pitch_angle;
  assign ang[2] = in_ch.yaw_angle;
  assign tgt[0] = in_ch.roll_target;
  assign tgt[1] = in_ch.pitch_target;
  assign tgt[2] = in_ch.yaw_target;

  for (genvar a = 0; a < LANES; a++) begin : g_lane
    assign cmd[a].start    = acc;
    assign cmd[a].clr      = (in_ch.opcode == OP_CLEAR);
    assign cmd[a].integ_en = in_ch.integrate_enable;
    assign cmd[a].err      = axis_err(tgt[a], ang[a], a == YAW_AXIS);
    assign cmd[a].ang      = ang[a];
    assign cmd[a].tstep    = in_ch.time_step;
    assign lcfg[a].kp  = regs_r[REG_KP][16*a +: 16];
    assign lcfg[a].ki  = regs_r[REG_KI][16*a +: 16];
    assign lcfg[a].kd  = regs_r[REG_KD][16*a +: 16];
    assign lcfg[a].ihi = regs_r[REG_IHI][16*a +: 16];
    assign lcfg[a].ilo = regs_r[REG_ILO][16*a +: 16];
    assign lcfg[a].dhi = regs_r[REG_DHI][16*a +: 16];
    assign lcfg[a].dlo = regs_r[REG_DLO][16*a +: 16];

    pid3_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[a]),
      .cfg   (lcfg[a]),
      .ack   (ack),
      .sts   (sts[a])
    );
  end

  pid3_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .sts    (sts),
    .ack    (ack),
    .out_ch (out_ch)
  );

  always_comb begin
    all_idle = 1'b1;
    for (int a = 0; a < LANES; a++) all_idle = all_idle & sts[a].idle;
  end

  a_busy_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.opcode == OP_UPDATE |=> !in_ch.ready)
    else $error("update transaction did not block input");

  a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> all_idle)
    else $error("lane running while controller not busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(busy_r))
    else $error("result appeared without an update");

  a_ack_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ack |=> !busy_r)
    else $error("busy held after lane release");

endmodule
